/* hw/rtl/bfcrc_pkg.sv */
// Shared types, codes and the CRC byte step for the CRC-hashed Bloom filter.
// No dependencies; used by the top level and the checker.
package bfcrc_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // register indexes of the configuration port
   localparam logic [3:0] CSR_POLY   = 4'd0;
   localparam logic [3:0] CSR_HCOUNT = 4'd1;

   localparam logic [31:0] POLY_RESET   = 32'h04C1_1DB7;
   localparam logic [3:0]  HCOUNT_RESET = 4'd3;

   typedef logic [3:0] csr_index_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] key_byte;
      logic       byte_present;
      logic       key_end;
   } req_type;

   typedef struct packed {
      logic [1:0] finished_op;
      logic       is_member;
   } rsp_type;

   // one byte through an MSB-first CRC-32, bitwise form
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  data,
                                            input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {data, 24'h00_0000};
      for (int b = 0; b < 8; b++) begin
         c = c[31] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/bfcrc_reduce.sv */
// Reduction of a 32-bit word modulo FILTER_BITS by reciprocal multiply:
// a pipeline of value, quotient, partial remainder and remainder registers,
// ending in one correcting subtract. Depends on nothing but its parameter.
module bfcrc_reduce #(
   parameter int FILTER_BITS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [31:0]                    value,
   output logic                           done,
   output logic [$clog2(FILTER_BITS)-1:0] remainder
);
   localparam int IW = $clog2(FILTER_BITS);
   // floor(2^32 / FILTER_BITS); the estimated quotient is low by at most one
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(FILTER_BITS));
   localparam logic [IW:0] DIVISOR = (IW+1)'(FILTER_BITS);

   logic [31:0]   val_ff, val_in;
   logic [63:0]   prod;
   logic [IW:0]   quo_ff, quo_in;
   logic [IW:0]   part_ff, part_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic [3:0]    stage_ff, stage_in;

   // partial remainder is below 2*FILTER_BITS, so IW+1 low bits are exact
   always_comb begin
      val_in   = go ? value : val_ff;
      prod     = {32'd0, val_ff} * {32'd0, RECIP};
      quo_in   = prod[32 +: IW+1];
      part_in  = val_ff[IW:0] - (quo_ff * DIVISOR);
      if (part_ff >= DIVISOR) begin
         rem_in = IW'(part_ff - DIVISOR);
      end else begin
         rem_in = part_ff[IW-1:0];
      end
      stage_in = {stage_ff[2:0], go};
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      quo_ff  <= quo_in;
      part_ff <= part_in;
      rem_ff  <= rem_in;
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign done      = stage_ff[3];
   assign remainder = rem_ff;

endmodule

/* hw/rtl/bloom_filter_crc_hashed.sv */
// Bloom filter top level: CRC sequencer, bit array memory, config registers.
// Depends on bfcrc_pkg and bfcrc_reduce.
//
// Usage. A command word on req_word is taken at a clock edge where start is
// high and busy is low. Insert and query words carry up to one key byte;
// key_end marks the last word of a key, and the opcode of that word picks
// insert or query. Clear zeroes the bit array and drops a partial key.
// Each finished key or clear shows one result on rsp_word for exactly one
// cycle with rsp_valid high; the receiver cannot stall it. Opcode 3 and
// non-final key words give no result.
// Timing: a key byte keeps busy high while the shared CRC step updates all
// MAX_HASHES lanes, one CRC lane per cycle. A key end then takes, per active
// hash, a launch state, the modulo reduction, then a read and a check or
// read-modify-write of one byte of the bit array (single port memory).
// The result shows the cycle after the last access. Clear sweeps all
// ceil(FILTER_BITS/8) array bytes, one array byte per cycle.
// Reset: synchronous; seeds and registers return to their defaults, then a
// clearing pass over all ceil(FILTER_BITS/8) array bytes zeroes the array
// with busy high. The configuration port (csr_*) is always ready.
module bloom_filter_crc_hashed #(
   parameter int FILTER_BITS = 4096,
   parameter int MAX_HASHES  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bfcrc_pkg::req_type     req_word,
   output logic                   rsp_valid,
   output bfcrc_pkg::rsp_type     rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bfcrc_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);
   import bfcrc_pkg::*;

   localparam int IW          = $clog2(FILTER_BITS);
   localparam int ARRAY_BYTES = (FILTER_BITS + 7) / 8;
   localparam int AW          = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1;
   localparam int HW          = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_SWEEP = 7'b000_0010,
      ST_CRC   = 7'b000_0100,
      ST_HASH  = 7'b000_1000,
      ST_RED   = 7'b001_0000,
      ST_RD    = 7'b010_0000,
      ST_CHK   = 7'b100_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [31:0]   crc_ff [MAX_HASHES];
   logic [31:0]   crc_in [MAX_HASHES];
   logic [31:0]   poly_ff;
   logic [3:0]    hcount_ff;
   logic [HW-1:0] h_ff, h_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          clr_pend_ff, clr_pend_in;
   logic [1:0]    op_ff, op_in;
   logic [7:0]    byte_ff, byte_in;
   logic          end_ff, end_in;
   logic          member_ff, member_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [7:0]    mem [ARRAY_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;

   logic          red_go, red_done;
   logic [IW-1:0] red_rem;
   logic [7:0]    bit_mask;
   logic [4:0]    k_eff;
   logic          last_hash, miss;

   bfcrc_reduce #(.FILTER_BITS(FILTER_BITS)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .go        (red_go),
      .value     (~crc_ff[h_ff]),
      .done      (red_done),
      .remainder (red_rem)
   );

   // hash_count of zero acts as one; above MAX_HASHES it saturates
   always_comb begin
      if (hcount_ff == 4'd0) begin
         k_eff = 5'd1;
      end else if (5'(hcount_ff) > 5'(MAX_HASHES)) begin
         k_eff = 5'(MAX_HASHES);
      end else begin
         k_eff = 5'(hcount_ff);
      end
   end

   assign last_hash = (5'(h_ff) + 5'd1) == k_eff;
   assign bit_mask  = 8'h80 >> red_rem[2:0];
   assign miss      = (rd_data_ff & bit_mask) == 8'h00;
   assign red_go    = (state_ff == ST_HASH);

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         mem_addr = sweep_ff;
      end else begin
         mem_addr = AW'(red_rem >> 3);
      end
      mem_we    = (state_ff == ST_SWEEP) ||
                  ((state_ff == ST_CHK) && (op_ff == OP_INSERT));
      mem_wdata = (state_ff == ST_SWEEP) ? 8'h00 : (rd_data_ff | bit_mask);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      h_in         = h_ff;
      sweep_in     = sweep_ff;
      clr_pend_in  = clr_pend_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      end_in       = end_ff;
      member_in    = member_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_word.opcode;
               byte_in   = req_word.key_byte;
               end_in    = req_word.key_end;
               member_in = 1'b1;
               h_in      = '0;
               if (req_word.opcode == OP_CLEAR) begin
                  for (int g = 0; g < MAX_HASHES; g++) begin
                     crc_in[g] = 32'(g);
                  end
                  sweep_in    = '0;
                  clr_pend_in = 1'b1;
                  state_in    = ST_SWEEP;
               end else if (req_word.opcode != OP_NONE) begin
                  if (req_word.byte_present) begin
                     state_in = ST_CRC;
                  end else if (req_word.key_end) begin
                     state_in = ST_HASH;
                  end
               end
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(ARRAY_BYTES - 1)) begin
               state_in = ST_IDLE;
               if (clr_pend_ff) begin
                  clr_pend_in  = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{finished_op: OP_CLEAR, is_member: 1'b0};
               end
            end
         end
         ST_CRC: begin
            crc_in[h_ff] = crc_byte(crc_ff[h_ff], byte_ff, poly_ff);
            h_in         = h_ff + HW'(1);
            if (h_ff == HW'(MAX_HASHES - 1)) begin
               h_in     = '0;
               state_in = end_ff ? ST_HASH : ST_IDLE;
            end
         end
         ST_HASH: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            if (red_done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if ((op_ff == OP_QUERY) && miss) begin
               member_in = 1'b0;
            end
            if (last_hash) begin
               for (int g = 0; g < MAX_HASHES; g++) begin
                  crc_in[g] = 32'(g);
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{finished_op: op_ff,
                                is_member: (op_ff == OP_QUERY) && member_ff && !miss};
               state_in     = ST_IDLE;
            end else begin
               h_in     = h_ff + HW'(1);
               state_in = ST_HASH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      member_ff <= member_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_SWEEP;
         h_ff         <= '0;
         sweep_ff     <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         poly_ff      <= POLY_RESET;
         hcount_ff    <= HCOUNT_RESET;
         for (int g = 0; g < MAX_HASHES; g++) begin
            crc_ff[g] <= 32'(g);
         end
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         sweep_ff     <= sweep_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         if (csr_valid && (csr_index == CSR_POLY)) begin
            poly_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == CSR_HCOUNT)) begin
            hcount_ff <= csr_wdata[3:0];
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* hw/rtl/bfcrc_checker.sv */
// Port-level checks for the Bloom filter, bound to the top level.
// Depends on bfcrc_pkg and bloom_filter_crc_hashed.
module bfcrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input bfcrc_pkg::req_type req_word,
   input logic               rsp_valid,
   input bfcrc_pkg::rsp_type rsp_word
);
   import bfcrc_pkg::*;

   // reset always starts the array clearing pass, with no result
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("no clearing pass after reset");

   // results never come in adjacent cycles
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a clear word always occupies the block
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.opcode == OP_CLEAR)) |=> busy)
      else $error("clear taken without a sweep");

   // an empty non-final key word does nothing
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_word.byte_present && !req_word.key_end &&
       (req_word.opcode != OP_CLEAR)) |=> !busy && !rsp_valid)
      else $error("empty key word caused activity");

   // only a query can answer member
   a_member_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.finished_op != OP_QUERY)) |-> !rsp_word.is_member)
      else $error("member flag on a non-query result");

endmodule

bind bloom_filter_crc_hashed bfcrc_checker u_bfcrc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
